FILE: rtl/core/bsbq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the buffered serial byte queues.
// No dependencies; imported by every module of the block.
package bsbq_pkg;

    localparam int RX_DEPTH = 16;
    localparam int TX_DEPTH = 16;
    localparam int RX_IW    = $clog2(RX_DEPTH);
    localparam int TX_IW    = $clog2(TX_DEPTH);
    localparam int LVL_W    = 4;
    localparam int CNT_W    = 13;

    typedef enum logic [1:0] {
        CMD_RX_BYTE    = 2'd0,
        CMD_HOST_READ  = 2'd1,
        CMD_HOST_WRITE = 2'd2,
        CMD_TX_DONE    = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_in;
    } t_in;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic             read_valid;
        logic [7:0]       line_byte;
        logic             line_send;
        logic             rx_dropped;
        logic             write_accepted;
        logic [LVL_W-1:0] rx_level;
        logic [LVL_W-1:0] tx_level;
    } t_out;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_ctrl;

    // Ring occupancy from write/read indices, wrapped to the level width.
    function automatic logic [LVL_W-1:0] ring_level(
        input logic [CNT_W-1:0] wr,
        input logic [CNT_W-1:0] rd,
        input logic [CNT_W-1:0] depth
    );
        logic [CNT_W-1:0] cnt;
        cnt = (wr >= rd) ? (wr - rd) : (wr + depth - rd);
        return cnt[LVL_W-1:0];
    endfunction

endpackage

FILE: rtl/core/bsbq_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: accept, execute, present result.
// Depends on bsbq_pkg.
module bsbq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bsbq_pkg::t_dp_ctrl  o_dp_ctrl
);
    import bsbq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= ST_EXEC;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    r_state     <= ST_RESP;
                    r_out_valid <= 1'b1;
                end
                ST_RESP: begin
                    if (i_out_ready) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= ST_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready     = r_in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_dp_ctrl.load = i_in_valid & r_in_ready;
    assign o_dp_ctrl.exec = (r_state == ST_EXEC);

endmodule

FILE: rtl/core/bsbq_dp.sv
`timescale 1ns / 1ps
// Ring stores, ring indices, line-busy flag and result register.
// Depends on bsbq_pkg.
module bsbq_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsbq_pkg::t_dp_ctrl  i_dp_ctrl,
    input  bsbq_pkg::t_in       i_in,
    output bsbq_pkg::t_out      o_out
);
    import bsbq_pkg::*;

    logic [7:0]       rx_mem [RX_DEPTH];
    logic [7:0]       tx_mem [TX_DEPTH];

    t_in              r_req;
    t_out             r_out;
    logic [RX_IW-1:0] r_rx_wr, r_rx_rd, n_rx_wr, n_rx_rd;
    logic [TX_IW-1:0] r_tx_wr, r_tx_rd, n_tx_wr, n_tx_rd;
    logic             r_line_busy, n_line_busy;

    logic [RX_IW-1:0] rx_wr_inc, rx_rd_inc;
    logic [TX_IW-1:0] tx_wr_inc, tx_rd_inc;
    logic             rx_full, rx_empty, tx_full, tx_empty;
    logic             push_rx, pop_rx, push_tx, pop_tx, dropped, accepted;

    assign rx_wr_inc = (r_rx_wr == RX_IW'(RX_DEPTH - 1)) ? '0 : r_rx_wr + 1'b1;
    assign rx_rd_inc = (r_rx_rd == RX_IW'(RX_DEPTH - 1)) ? '0 : r_rx_rd + 1'b1;
    assign tx_wr_inc = (r_tx_wr == TX_IW'(TX_DEPTH - 1)) ? '0 : r_tx_wr + 1'b1;
    assign tx_rd_inc = (r_tx_rd == TX_IW'(TX_DEPTH - 1)) ? '0 : r_tx_rd + 1'b1;

    assign rx_full  = (rx_wr_inc == r_rx_rd);
    assign rx_empty = (r_rx_wr == r_rx_rd);
    assign tx_full  = (tx_wr_inc == r_tx_rd);
    assign tx_empty = (r_tx_wr == r_tx_rd);

    always_comb begin
        push_rx     = 1'b0;
        pop_rx      = 1'b0;
        push_tx     = 1'b0;
        pop_tx      = 1'b0;
        dropped     = 1'b0;
        accepted    = 1'b0;
        n_line_busy = r_line_busy;
        case (r_req.cmd)
            CMD_RX_BYTE: begin
                push_rx = ~rx_full;
                dropped = rx_full;
            end
            CMD_HOST_READ: begin
                pop_rx = ~rx_empty;
            end
            CMD_HOST_WRITE: begin
                push_tx  = ~tx_full;
                accepted = ~tx_full;
                pop_tx   = ~tx_full & ~r_line_busy;
                if (pop_tx) begin
                    n_line_busy = 1'b1;
                end
            end
            CMD_TX_DONE: begin
                pop_tx      = ~tx_empty;
                n_line_busy = ~tx_empty;
            end
            default: begin
                n_line_busy = r_line_busy;
            end
        endcase
        n_rx_wr = push_rx ? rx_wr_inc : r_rx_wr;
        n_rx_rd = pop_rx  ? rx_rd_inc : r_rx_rd;
        n_tx_wr = push_tx ? tx_wr_inc : r_tx_wr;
        n_tx_rd = pop_tx  ? tx_rd_inc : r_tx_rd;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr     <= '0;
            r_rx_rd     <= '0;
            r_tx_wr     <= '0;
            r_tx_rd     <= '0;
            r_line_busy <= 1'b0;
        end else if (i_dp_ctrl.exec) begin
            r_rx_wr     <= n_rx_wr;
            r_rx_rd     <= n_rx_rd;
            r_tx_wr     <= n_tx_wr;
            r_tx_rd     <= n_tx_rd;
            r_line_busy <= n_line_busy;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.load) begin
            r_req <= i_in;
        end
    end

    // stores and registered result; pop on an empty ring bypasses the write
    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.exec) begin
            if (push_rx) begin
                rx_mem[r_rx_wr] <= r_req.data_in;
            end
            if (push_tx) begin
                tx_mem[r_tx_wr] <= r_req.data_in;
            end
            r_out.read_byte      <= pop_rx ? rx_mem[r_rx_rd] : 8'd0;
            r_out.read_valid     <= pop_rx;
            r_out.line_byte      <= pop_tx ? (tx_empty ? r_req.data_in : tx_mem[r_tx_rd])
                                           : 8'd0;
            r_out.line_send      <= pop_tx;
            r_out.rx_dropped     <= dropped;
            r_out.write_accepted <= accepted;
            r_out.rx_level       <= ring_level(CNT_W'(n_rx_wr), CNT_W'(n_rx_rd),
                                               CNT_W'(RX_DEPTH));
            r_out.tx_level       <= ring_level(CNT_W'(n_tx_wr), CNT_W'(n_tx_rd),
                                               CNT_W'(TX_DEPTH));
        end
    end

    assign o_out = r_out;

endmodule

FILE: rtl/core/buffered_serial_byte_queues_core.sv
`timescale 1ns / 1ps
// Buffered serial byte queues: receive and transmit rings, one empty slot each.
// An accepted request is executed in the execute state; its result is registered
// there and offered from the response state. The sequencer holds one
// request from acceptance until its result is taken.
// Reset (synchronous, active low) empties both rings and idles the line.
module buffered_serial_byte_queues_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bsbq_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bsbq_pkg::t_out  o_out
);
    import bsbq_pkg::*;

    // load: request captured; exec: rings updated and result registered
    t_dp_ctrl dp_ctrl;

    // Sequencer: idle -> execute -> hold result until taken.
    bsbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_dp_ctrl   (dp_ctrl)
    );

    // Datapath: both rings, the line-busy flag and the result register.
    // A host write to an idle line is queued and popped in the same step.
    bsbq_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dp_ctrl (dp_ctrl),
        .i_in      (i_in),
        .o_out     (o_out)
    );

    // Only one request in flight: never ready while a result is on offer.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("accepting while a result is pending");

    // An accepted request yields its result once the execute state has passed.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##1 o_out_valid)
        else $error("result did not appear after request");

    // A dropped byte means the receive ring stays full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.rx_dropped) |-> (o_out.rx_level == LVL_W'(RX_DEPTH - 1)))
        else $error("byte dropped with room in receive ring");

    // A read result and a line send cannot come from the same request.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.read_valid && o_out.line_send))
        else $error("read and send in one result");

endmodule

FILE: tb/tb_buffered_serial_byte_queues_core.sv
`timescale 1ns / 1ps
// Self-checking bench for buffered_serial_byte_queues_core: receive and transmit rings.
// Depends on bsbq_pkg (request/result types, ring depths) and the core RTL only.
module tb_buffered_serial_byte_queues_core;
    import bsbq_pkg::*;

    // Traffic shapes for the random part: a run of one event kind, or a mix.
    typedef enum int {
        BURST_RX,
        BURST_READ,
        BURST_WRITE,
        BURST_DONE,
        BURST_MIXED
    } t_burst;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_in  req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b1;
    t_out rsp;

    // Shared by both sides: random idling allowed in the current phase.
    bit   idle_enabled = 1'b0;
    int   stall_left   = 0;
    int   outcome_errors = 0;

    // Predicted results, oldest first, one per accepted request.
    t_out pending_outcomes[$];
    t_out want;

    // Shadow of the two rings and the line state.
    logic [7:0] rx_ring [RX_DEPTH];
    logic [7:0] tx_ring [TX_DEPTH];
    int         rx_wr, rx_rd, tx_wr, tx_rd;
    bit         line_busy;

    buffered_serial_byte_queues_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in        (req),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_out       (rsp)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------------
    // Ring shadow
    // ---------------------------------------------------------------------
    function automatic int ring_next(input int idx, input int depth);
        return (idx + 1 >= depth) ? 0 : idx + 1;
    endfunction

    function automatic int ring_fill(input int wr, input int rd, input int depth);
        return (wr >= rd) ? (wr - rd) : (wr + depth - rd);
    endfunction

    // Oldest queued transmit byte goes to the line; caller checks non-empty.
    function automatic logic [7:0] launch_tx_byte();
        logic [7:0] b;
        b     = tx_ring[tx_rd];
        tx_rd = ring_next(tx_rd, TX_DEPTH);
        line_busy = 1'b1;
        return b;
    endfunction

    function automatic t_out predict_outcome(input t_in r);
        t_out o;
        int   nxt;
        o = '0;
        case (r.cmd)
            CMD_RX_BYTE: begin
                nxt = ring_next(rx_wr, RX_DEPTH);
                if (nxt == rx_rd) begin
                    // ring full: byte lost
                    o.rx_dropped = 1'b1;
                end else begin
                    rx_ring[rx_wr] = r.data_in;
                    rx_wr = nxt;
                end
            end
            CMD_HOST_READ: begin
                if (rx_rd != rx_wr) begin
                    o.read_byte  = rx_ring[rx_rd];
                    o.read_valid = 1'b1;
                    rx_rd = ring_next(rx_rd, RX_DEPTH);
                end
            end
            CMD_HOST_WRITE: begin
                nxt = ring_next(tx_wr, TX_DEPTH);
                if (nxt != tx_rd) begin
                    tx_ring[tx_wr] = r.data_in;
                    tx_wr = nxt;
                    o.write_accepted = 1'b1;
                    // idle line: the byte goes straight out
                    if (!line_busy) begin
                        o.line_byte = launch_tx_byte();
                        o.line_send = 1'b1;
                    end
                end
            end
            default: begin
                if (tx_rd != tx_wr) begin
                    o.line_byte = launch_tx_byte();
                    o.line_send = 1'b1;
                end else begin
                    line_busy = 1'b0;
                end
            end
        endcase
        // levels wrap to the field width
        o.rx_level = LVL_W'(ring_fill(rx_wr, rx_rd, RX_DEPTH));
        o.tx_level = LVL_W'(ring_fill(tx_wr, tx_rd, TX_DEPTH));
        return o;
    endfunction

    // ---------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------
    // Optional idle burst, then present the request and hold it until taken.
    task automatic issue_request(input t_cmd c, input logic [7:0] d);
        t_in r;
        int  gap;
        r.cmd     = c;
        r.data_in = d;
        gap = 0;
        if (idle_enabled && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0) begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        pending_outcomes.push_back(predict_outcome(r));
    endtask

    // Withdraw valid and hold off until every predicted result is back.
    task automatic wait_for_outcomes();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ---------------------------------------------------------------------
    always @(negedge clk) begin
        if (!idle_enabled) begin
            stall_left <= 0;
            rsp_ready  <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 18);
            rsp_ready  <= 1'b0;
        end else begin
            rsp_ready <= 1'b1;
        end
    end

    function automatic string show_outcome(input t_out o);
        return $sformatf("rd=%02h rv=%0b line=%02h send=%0b drop=%0b wacc=%0b %s",
                         o.read_byte, o.read_valid, o.line_byte, o.line_send,
                         o.rx_dropped, o.write_accepted,
                         $sformatf("rxl=%0d txl=%0d", o.rx_level, o.tx_level));
    endfunction

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
                outcome_errors++;
                if (outcome_errors <= 10)
                    $display("%0t: result with no request outstanding: %s",
                             $realtime, show_outcome(rsp));
            end else begin
                want = pending_outcomes.pop_front();
                if (rsp.read_byte      !== want.read_byte      ||
                    rsp.read_valid     !== want.read_valid     ||
                    rsp.line_byte      !== want.line_byte      ||
                    rsp.line_send      !== want.line_send      ||
                    rsp.rx_dropped     !== want.rx_dropped     ||
                    rsp.write_accepted !== want.write_accepted ||
                    rsp.rx_level       !== want.rx_level       ||
                    rsp.tx_level       !== want.tx_level) begin
                    outcome_errors++;
                    if (outcome_errors <= 10)
                        $display("%0t: exp %s\n            got %s", $realtime,
                                 show_outcome(want), show_outcome(rsp));
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    // Empty-ring read, idle transmit-done, extreme bytes, immediate launch.
    task automatic test_directed_events();
        issue_request(CMD_HOST_READ,  8'hFF);
        issue_request(CMD_TX_DONE,    8'hFF);
        issue_request(CMD_RX_BYTE,    8'h00);
        issue_request(CMD_RX_BYTE,    8'hFF);
        issue_request(CMD_RX_BYTE,    8'h5A);
        repeat (4) issue_request(CMD_HOST_READ, 8'h00);
        issue_request(CMD_HOST_WRITE, 8'h00);
        issue_request(CMD_HOST_WRITE, 8'hFF);
        issue_request(CMD_HOST_WRITE, 8'hA5);
        repeat (3) issue_request(CMD_TX_DONE, 8'h00);
        issue_request(CMD_TX_DONE,    8'h00);
        issue_request(CMD_HOST_WRITE, 8'h81);
        issue_request(CMD_TX_DONE,    8'h7E);
    endtask

    // Overrun both rings, then empty them; ends with a full drain.
    task automatic test_ring_limits();
        repeat (RX_DEPTH + 2) issue_request(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
        repeat (RX_DEPTH + 1) issue_request(CMD_HOST_READ, 8'($urandom_range(0, 255)));
        // first write launches, the next TX_DEPTH-1 fill, the rest bounce
        repeat (TX_DEPTH + 2) issue_request(CMD_HOST_WRITE, 8'($urandom_range(0, 255)));
        repeat (TX_DEPTH + 1) issue_request(CMD_TX_DONE, 8'($urandom_range(0, 255)));
        wait_for_outcomes();
    endtask

    // Runs of one event kind push the rings to both ends; mixed runs add noise.
    task automatic test_random_traffic(input int n_items);
        int     sent;
        int     len;
        t_burst kind;
        t_cmd   c;
        sent = 0;
        while (sent < n_items) begin
            kind = t_burst'($urandom_range(0, 4));
            len  = $urandom_range(1, 20);
            repeat (len) begin
                case (kind)
                    BURST_RX:    c = CMD_RX_BYTE;
                    BURST_READ:  c = CMD_HOST_READ;
                    BURST_WRITE: c = CMD_HOST_WRITE;
                    BURST_DONE:  c = CMD_TX_DONE;
                    default:     c = t_cmd'($urandom_range(0, 3));
                endcase
                issue_request(c, 8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        for (int i = 0; i < RX_DEPTH; i++) rx_ring[i] = '0;
        for (int i = 0; i < TX_DEPTH; i++) tx_ring[i] = '0;
        rx_wr = 0; rx_rd = 0; tx_wr = 0; tx_rd = 0;
        line_busy = 1'b0;

        // hold reset over rising edges, then release mid-cycle
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_enabled = 1'b1;
        test_directed_events();
        test_ring_limits();
        test_random_traffic(300);
        idle_enabled = 1'b0;
        test_random_traffic(150);
        idle_enabled = 1'b1;
        test_random_traffic(150);
        // quiet tail: no idling on either side
        idle_enabled = 1'b0;
        test_random_traffic(80);

        wait_for_outcomes();
        repeat (8) @(posedge clk);
        if (outcome_errors == 0 && pending_outcomes.size() == 0) begin
            $display("buffered_serial_byte_queues_core: match");
        end else begin
            $display("buffered_serial_byte_queues_core: mismatch");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #3_000_000;
        $display("buffered_serial_byte_queues_core: mismatch");
        $finish;
    end

endmodule
